### sv/met_pkg.sv
`timescale 1ns / 1ps

package met_pkg;

  localparam int COORD_W  = 32;
  localparam int STEP_W   = 31;
  localparam int SIZE_W   = 12;
  localparam int LIMIT_W  = 16;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_RE    = 3'd0,
    REG_CENTER_IM    = 3'd1,
    REG_PIXEL_STEP   = 3'd2,
    REG_MAX_ITER     = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAPX,
    S_MAPY,
    S_MAPW,
    S_SQR,
    S_SQI,
    S_XPR,
    S_UPD,
    S_DONE
  } met_state_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // a + b, clamped to the signed coordinate range
  function automatic coord_t sat_add(input prod_t a, input coord_t b);
    logic [PROD_W:0] sum;
    sum = {a[PROD_W-1], a} + {{(PROD_W-COORD_W+1){b[COORD_W-1]}}, b};
    if (sum[PROD_W:COORD_W-1] == '0 || sum[PROD_W:COORD_W-1] == '1) begin
      return coord_t'(sum[COORD_W-1:0]);
    end else if (sum[PROD_W]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

### sv/met_if.sv
`timescale 1ns / 1ps

interface met_pix_if #(parameter int PIXEL_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface met_res_if #(parameter int ITER_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [ITER_BITS-1:0] escape_count;
  logic                 inside_res;
  modport source (output valid, escape_count, inside_res, input ready);
  modport sink   (input valid, escape_count, inside_res, output ready);
endinterface

interface met_cfg_if import met_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/mandelbrot_escape_time_pixel_unit.sv
`timescale 1ns / 1ps

// Escape-time evaluator for one pixel. A pixel (x, y) is mapped to
// c = (2*pixel - size) * step / 2 + centre per axis (Q4.28, saturating), then
// z = z*z + c is iterated from z = c; the result is the index of the first
// iteration whose |z|^2 exceeded 4, or inside_res = 1 when max_iterations
// passes without escape. All products go through one shared 32x32 signed
// multiplier: mapping runs through the MAPX, MAPY and MAPW states and each
// iteration through SQR (re^2), SQI (im^2), XPR (re*im) and UPD (update).
// A pixel that escapes at index k runs k + 1 iterations and an inside pixel
// runs max_iterations. One pixel is in flight at a time; the result sits in
// an output register, so the next pixel is taken while it waits, and that
// pixel holds in its last state until the register is free. Configuration
// writes are always accepted and must be made only while the unit is idle.
module mandelbrot_escape_time_pixel_unit import met_pkg::*; #(
  parameter int FRAC_BITS  = 28,
  parameter int ITER_BITS  = 16,
  parameter int PIXEL_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  met_cfg_if.sink   cfg,
  met_pix_if.sink   pix_in,
  met_res_if.source res_out
);

  localparam int TWICE_W = ((PIXEL_BITS > SIZE_W) ? PIXEL_BITS : SIZE_W) + 2;
  localparam logic [PROD_W:0] ESC_BOUND = (PROD_W+1)'(4) << (2 * FRAC_BITS);

  // configuration
  coord_t              center_re;
  coord_t              center_im;
  logic [STEP_W-1:0]   pixel_step;
  logic [ITER_BITS-1:0] max_iter;
  logic [SIZE_W-1:0]   image_width;
  logic [SIZE_W-1:0]   image_height;

  // datapath
  met_state_t           state, state_next;
  logic [PIXEL_BITS-1:0] px, py;
  coord_t               cr, ci, zr, zi;
  prod_t                prod, r2, diff;
  logic                 esc;
  logic [ITER_BITS-1:0] iter;
  logic [ITER_BITS-1:0] iter_inc;
  logic [ITER_BITS-1:0] res_count;
  logic                 res_inside;
  logic                 out_valid;
  logic [ITER_BITS-1:0] out_count;
  logic                 out_inside;

  logic signed [TWICE_W-1:0] twice_x, twice_y;
  coord_t               mul_a, mul_b;
  logic                 out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_re    <= -32'sd134217728;
      center_im    <= '0;
      pixel_step   <= STEP_W'(1006633);
      max_iter     <= ITER_BITS'(10);
      image_width  <= SIZE_W'(800);
      image_height <= SIZE_W'(800);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_CENTER_RE:    center_re    <= coord_t'(cfg.data);
        REG_CENTER_IM:    center_im    <= coord_t'(cfg.data);
        REG_PIXEL_STEP:   pixel_step   <= cfg.data[STEP_W-1:0];
        REG_MAX_ITER:     max_iter     <= ITER_BITS'(cfg.data[LIMIT_W-1:0]);
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign twice_x  = TWICE_W'({px, 1'b0}) - TWICE_W'(image_width);
  assign twice_y  = TWICE_W'({py, 1'b0}) - TWICE_W'(image_height);
  assign iter_inc = iter + 1'b1;
  assign out_free = !out_valid || res_out.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (pix_in.valid) state_next = S_MAPX;
      S_MAPX: state_next = S_MAPY;
      S_MAPY: state_next = S_MAPW;
      S_MAPW: state_next = (max_iter == '0) ? S_DONE : S_SQR;
      S_SQR:  state_next = S_SQI;
      S_SQI:  state_next = S_XPR;
      S_XPR:  state_next = S_UPD;
      S_UPD:  state_next = (esc || iter_inc == max_iter) ? S_DONE : S_SQR;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier operand select and handshake
  always_comb begin
    pix_in.ready = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state)
      S_IDLE: pix_in.ready = 1'b1;
      S_MAPX: begin
        mul_a = {{(COORD_W-TWICE_W){twice_x[TWICE_W-1]}}, twice_x};
        mul_b = {1'b0, pixel_step};
      end
      S_MAPY: begin
        mul_a = {{(COORD_W-TWICE_W){twice_y[TWICE_W-1]}}, twice_y};
        mul_b = {1'b0, pixel_step};
      end
      S_SQR: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_SQI: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_XPR: begin
        mul_a = zr;
        mul_b = zi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (pix_in.valid) begin
          px <= pix_in.pixel_x;
          py <= pix_in.pixel_y;
        end
      end
      S_MAPY: begin
        cr <= sat_add(prod >>> 1, center_re);
        zr <= sat_add(prod >>> 1, center_re);
      end
      S_MAPW: begin
        ci         <= sat_add(prod >>> 1, center_im);
        zi         <= sat_add(prod >>> 1, center_im);
        iter       <= '0;
        res_count  <= '0;
        res_inside <= 1'b1;
      end
      S_SQI: r2 <= prod;
      S_XPR: begin
        // both squares are non-negative, so the sum cannot wrap in 65 bits
        esc  <= ({1'b0, r2} + {1'b0, prod}) > ESC_BOUND;
        diff <= r2 - prod;
      end
      S_UPD: begin
        if (esc) begin
          res_count  <= iter;
          res_inside <= 1'b0;
        end else begin
          zr         <= sat_add(diff >>> FRAC_BITS, cr);
          zi         <= sat_add(prod >>> (FRAC_BITS - 1), ci);
          iter       <= iter_inc;
          res_count  <= '0;
          res_inside <= 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_count  <= res_count;
          out_inside <= res_inside;
        end
      end
      default: ;
    endcase
  end

  assign res_out.valid        = out_valid;
  assign res_out.escape_count = out_count;
  assign res_out.inside_res   = out_inside;

  a_accept_starts_map: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> state == S_MAPX)
    else $error("accepted item did not start mapping");

  a_iter_below_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_SQR |-> iter < max_iter)
    else $error("iteration started at or past the limit");

  a_iter_advances: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && !esc && iter_inc != max_iter
    |=> state == S_SQR && iter == $past(iter_inc))
    else $error("iteration counter did not advance");

  a_inside_zero_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res_inside |-> res_count == '0)
    else $error("inside result carries a non-zero count");

endmodule
